### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define TARC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold at every rising edge outside reset
`define TARC_ALWAYS(label, cond, msg) \
  `TARC_ASSERT(label, (1'b1 |-> (cond)), msg)

`endif

### hw/rtl/tarc_pkg.sv
// types and constants of the throttle actuator ramp controller
package tarc_pkg;

  localparam int POS_W       = 16;
  localparam int TIME_W      = 32;
  localparam int PWM_W       = 8;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int ELAPSED_W   = 16;
  // shift of the reciprocal used for elapsed / DUTY_CYCLE_MS, exact for 16-bit
  // dividends and divisors up to 1000
  localparam int RECIP_SHIFT = 26;

  localparam logic [PWM_W-1:0] PWM_FULL = 8'hFF;
  localparam logic [PWM_W-1:0] PWM_OFF  = 8'h00;

  typedef enum logic [1:0] {
    DIR_IDLE   = 2'd0,
    DIR_PULL   = 2'd1,
    DIR_LOOSEN = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_POSITION    = 3'd0,
    REG_MAX_POSITION    = 3'd1,
    REG_TOLERANCE       = 3'd2,
    REG_SLOW_THRESHOLD  = 3'd3,
    REG_RAMP_UP_MS      = 3'd4,
    REG_RAMP_DOWN_MS    = 3'd5,
    REG_SLOW_PWM_PULL   = 3'd6,
    REG_SLOW_PWM_LOOSEN = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] min_position;
    logic [POS_W-1:0] max_position;
    logic [POS_W-1:0] tolerance;
    logic [POS_W-1:0] slow_threshold;
    logic [CFG_W-1:0] ramp_up_ms;
    logic [CFG_W-1:0] ramp_down_ms;
    logic [PWM_W-1:0] slow_pwm_pull;
    logic [PWM_W-1:0] slow_pwm_loosen;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  pot_position;
    logic [TIME_W-1:0] now_ms;
    logic              new_setpoint;
    logic [POS_W-1:0]  target_position;
    logic              clutch_allow;
  } in_t;

  // tracking stage to drive stage
  typedef struct packed {
    logic                 zero_pwm;
    logic                 drive;
    logic                 in1;
    logic                 pull;
    logic                 slow;
    logic [PWM_W-1:0]     slow_pwm;
    logic                 in_window;
    logic [ELAPSED_W-1:0] elapsed;
    logic [ELAPSED_W-1:0] quot;
    logic                 allow;
  } s2_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm_level;
    logic             bridge_in1;
    logic             bridge_in2;
    logic             solenoid_close;
  } out_t;

endpackage

### hw/rtl/tarc_ifs.sv
// valid/ready channel interfaces for control ticks and drive results
interface tarc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pot_position;
  logic [31:0] now_ms;
  logic        new_setpoint;
  logic [15:0] target_position;
  logic        clutch_allow;

  modport source (output valid, pot_position, now_ms, new_setpoint, target_position,
                  clutch_allow, input ready);
  modport sink (input valid, pot_position, now_ms, new_setpoint, target_position,
                clutch_allow, output ready);
endinterface

interface tarc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_level;
  logic       bridge_in1;
  logic       bridge_in2;
  logic       solenoid_close;

  modport source (output valid, pwm_level, bridge_in1, bridge_in2, solenoid_close,
                  input ready);
  modport sink (input valid, pwm_level, bridge_in1, bridge_in2, solenoid_close,
                output ready);
endinterface

### hw/rtl/tarc_cfg.sv
// configuration register file
module tarc_cfg import tarc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_position    <= 16'd0;
      cfg_r.max_position    <= 16'hFFFF;
      cfg_r.tolerance       <= 16'd16;
      cfg_r.slow_threshold  <= 16'd256;
      cfg_r.ramp_up_ms      <= 16'd200;
      cfg_r.ramp_down_ms    <= 16'd200;
      cfg_r.slow_pwm_pull   <= 8'd128;
      cfg_r.slow_pwm_loosen <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_MIN_POSITION:    cfg_r.min_position    <= cfg_data;
        REG_MAX_POSITION:    cfg_r.max_position    <= cfg_data;
        REG_TOLERANCE:       cfg_r.tolerance       <= cfg_data;
        REG_SLOW_THRESHOLD:  cfg_r.slow_threshold  <= cfg_data;
        REG_RAMP_UP_MS:      cfg_r.ramp_up_ms      <= cfg_data;
        REG_RAMP_DOWN_MS:    cfg_r.ramp_down_ms    <= cfg_data;
        REG_SLOW_PWM_PULL:   cfg_r.slow_pwm_pull   <= cfg_data[PWM_W-1:0];
        REG_SLOW_PWM_LOOSEN: cfg_r.slow_pwm_loosen <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/tarc_track.sv
// setpoint tracking: target, direction and ramp start state, ramp quotient
module tarc_track import tarc_pkg::*; #(
  parameter int DUTY_CYCLE_MS = 20
) (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  in_t  item,
  input  cfg_t cfg,
  output s2_t  stage_r
);

  localparam int     RECIP_W = RECIP_SHIFT + 1;
  localparam int     PROD_W  = ELAPSED_W + RECIP_W;
  localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + longint'(DUTY_CYCLE_MS) - 1)
                               / longint'(DUTY_CYCLE_MS);

  logic [POS_W-1:0]  target_r, target_nxt;
  dir_t              dir_r, dir_nxt;
  logic [TIME_W-1:0] ramp_start_r, ramp_start_nxt;

  logic [POS_W-1:0]  lo_clamp, sp_target, sp_diff, err;
  logic              sp_in_tol, keep_dir, active, err_in_tol;
  logic [TIME_W-1:0] elapsed_full;
  logic [CFG_W-1:0]  window;
  logic [PROD_W-1:0] prod;
  s2_t               stage_nxt;

  always_comb begin
    lo_clamp  = (item.target_position < cfg.min_position) ? cfg.min_position
                                                          : item.target_position;
    sp_target = (lo_clamp > cfg.max_position) ? cfg.max_position : lo_clamp;
    sp_diff   = (item.pot_position > sp_target) ? item.pot_position - sp_target
                                                : sp_target - item.pot_position;
    sp_in_tol = sp_diff < cfg.tolerance;
    keep_dir  = ((sp_target > item.pot_position) && (dir_r == DIR_PULL)) ||
                ((sp_target < item.pot_position) && (dir_r == DIR_LOOSEN));

    target_nxt     = target_r;
    dir_nxt        = dir_r;
    ramp_start_nxt = ramp_start_r;
    if (item.new_setpoint) begin
      target_nxt = sp_target;
      if (!sp_in_tol && !keep_dir) begin
        dir_nxt        = (sp_target > item.pot_position) ? DIR_PULL : DIR_LOOSEN;
        ramp_start_nxt = item.now_ms;
      end
    end

    err        = (item.pot_position > target_nxt) ? item.pot_position - target_nxt
                                                  : target_nxt - item.pot_position;
    err_in_tol = err < cfg.tolerance;
    active     = dir_nxt != DIR_IDLE;

    elapsed_full = item.now_ms - ramp_start_nxt;
    window       = (dir_nxt == DIR_PULL) ? cfg.ramp_up_ms : cfg.ramp_down_ms;
    // quotient of elapsed by the duty period through a reciprocal multiply
    prod = {{RECIP_W{1'b0}}, elapsed_full[ELAPSED_W-1:0]} *
           {{ELAPSED_W{1'b0}}, RECIP_W'(RECIP)};

    stage_nxt.zero_pwm  = (item.new_setpoint && sp_in_tol) || !item.clutch_allow ||
                          (active && err_in_tol);
    stage_nxt.drive     = active && !err_in_tol;
    stage_nxt.in1       = item.pot_position < target_nxt;
    stage_nxt.pull      = dir_nxt == DIR_PULL;
    stage_nxt.slow      = err <= cfg.slow_threshold;
    stage_nxt.slow_pwm  = (dir_nxt == DIR_PULL) ? cfg.slow_pwm_pull : cfg.slow_pwm_loosen;
    stage_nxt.in_window = elapsed_full <= {{(TIME_W-CFG_W){1'b0}}, window};
    stage_nxt.elapsed   = elapsed_full[ELAPSED_W-1:0];
    stage_nxt.quot      = prod[RECIP_SHIFT +: ELAPSED_W];
    stage_nxt.allow     = item.clutch_allow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      dir_r        <= DIR_IDLE;
      ramp_start_r <= '0;
    end else if (load) begin
      target_r     <= target_nxt;
      dir_r        <= dir_nxt;
      ramp_start_r <= ramp_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

### hw/rtl/tarc_drive.sv
// duty pattern and pwm selection, held bridge and pwm outputs
module tarc_drive import tarc_pkg::*; #(
  parameter int DUTY_CYCLE_MS     = 20,
  parameter int UP_INITIAL_DUTY   = 5,
  parameter int DOWN_INITIAL_DUTY = 5,
  parameter int UP_DUTY_STEP      = 2,
  parameter int DOWN_DUTY_STEP    = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  s2_t  stage,
  output out_t out_r
);

  localparam logic [31:0] UP_SLOPE   = 32'(DUTY_CYCLE_MS + UP_DUTY_STEP);
  localparam logic [31:0] DOWN_SLOPE = 32'(DUTY_CYCLE_MS + DOWN_DUTY_STEP);
  localparam logic [31:0] UP_INIT    = 32'(UP_INITIAL_DUTY);
  localparam logic [31:0] DOWN_INIT  = 32'(DOWN_INITIAL_DUTY);

  logic [31:0] slope, init, thr;
  logic        off;
  out_t        out_nxt;

  // phase > init + cycle*step  <=>  elapsed > init + cycle*(period + step)
  always_comb begin
    slope = stage.pull ? UP_SLOPE : DOWN_SLOPE;
    init  = stage.pull ? UP_INIT : DOWN_INIT;
    thr   = init + {{(32-ELAPSED_W){1'b0}}, stage.quot} * slope;
    off   = stage.in_window && ({{(32-ELAPSED_W){1'b0}}, stage.elapsed} > thr);

    out_nxt                = out_r;
    out_nxt.solenoid_close = stage.allow;
    if (stage.drive) begin
      out_nxt.bridge_in1 = stage.in1;
      out_nxt.bridge_in2 = !stage.in1;
      if (off) begin
        out_nxt.pwm_level = PWM_OFF;
      end else if (!stage.slow) begin
        out_nxt.pwm_level = PWM_FULL;
      end else begin
        out_nxt.pwm_level = stage.slow_pwm;
      end
    end else if (stage.zero_pwm) begin
      out_nxt.pwm_level = PWM_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

### hw/rtl/throttle_actuator_ramp_controller_unit.sv
// throttle actuator ramp controller, top level
// an accepted tick moves from the input register through the tracking register to the
//   output register, whose result is then offered on the output channel
// throughput: one tick per cycle unless the output channel stalls; the input, tracking
//   (reciprocal multiply) and output (threshold multiply) registers each hold one
// reset: synchronous, clears stage valids, target, direction, ramp start and held
//   outputs, and loads the configuration defaults; no clearing pass
`include "assert_macros.svh"

module throttle_actuator_ramp_controller_unit import tarc_pkg::*; #(
  parameter int DUTY_CYCLE_MS     = 20,
  parameter int UP_INITIAL_DUTY   = 5,
  parameter int DOWN_INITIAL_DUTY = 5,
  parameter int UP_DUTY_STEP      = 2,
  parameter int DOWN_DUTY_STEP    = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tarc_in_if.sink              in_chan,
  tarc_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic v1_r, v1_nxt, v2_r, v2_nxt, vo_r, vo_nxt;
  logic ready_o, ready2, ready1, in_take, move1, move2;
  in_t  s1_r;
  cfg_t cfg;
  s2_t  s2;
  out_t res;

  // per-stage handshake, a stage takes a transaction when it is empty or drains
  always_comb begin
    ready_o = !vo_r || out_chan.ready;
    ready2  = !v2_r || ready_o;
    ready1  = !v1_r || ready2;
    in_take = in_chan.valid && ready1;
    move1   = v1_r && ready2;
    move2   = v2_r && ready_o;
    v1_nxt  = in_take || (v1_r && !move1);
    v2_nxt  = move1 || (v2_r && !move2);
    vo_nxt  = move2 || (vo_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.pot_position    <= in_chan.pot_position;
      s1_r.now_ms          <= in_chan.now_ms;
      s1_r.new_setpoint    <= in_chan.new_setpoint;
      s1_r.target_position <= in_chan.target_position;
      s1_r.clutch_allow    <= in_chan.clutch_allow;
    end
  end

  tarc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_r     (cfg)
  );

  tarc_track #(
    .DUTY_CYCLE_MS (DUTY_CYCLE_MS)
  ) u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (move1),
    .item    (s1_r),
    .cfg     (cfg),
    .stage_r (s2)
  );

  tarc_drive #(
    .DUTY_CYCLE_MS     (DUTY_CYCLE_MS),
    .UP_INITIAL_DUTY   (UP_INITIAL_DUTY),
    .DOWN_INITIAL_DUTY (DOWN_INITIAL_DUTY),
    .UP_DUTY_STEP      (UP_DUTY_STEP),
    .DOWN_DUTY_STEP    (DOWN_DUTY_STEP)
  ) u_drive (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (move2),
    .stage (s2),
    .out_r (res)
  );

  assign in_chan.ready           = ready1;
  assign out_chan.valid          = vo_r;
  assign out_chan.pwm_level      = res.pwm_level;
  assign out_chan.bridge_in1     = res.bridge_in1;
  assign out_chan.bridge_in2     = res.bridge_in2;
  assign out_chan.solenoid_close = res.solenoid_close;

  `TARC_ASSERT(a_free_out_takes_input, (!vo_r |-> in_chan.ready), "input stalled with free output")
  `TARC_ASSERT(a_drain_fills_output, (move2 |=> vo_r), "result lost at output register")
  `TARC_ALWAYS(a_bridge_exclusive, !(res.bridge_in1 && res.bridge_in2), "both bridge inputs high")

endmodule

### tb/tb_throttle_actuator_ramp_controller_unit.sv
// self-checking testbench for the throttle actuator ramp controller: directed and random ticks
`timescale 1ns / 100ps

module tb_throttle_actuator_ramp_controller_unit import tarc_pkg::*;;

  localparam int DUTY_MS    = 20;
  localparam int UP_INIT    = 5;
  localparam int DOWN_INIT  = 5;
  localparam int UP_STEP    = 2;
  localparam int DOWN_STEP  = 2;
  localparam int MAX_PRINTS = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tarc_in_if  in_chan ();
  tarc_out_if out_chan ();

  throttle_actuator_ramp_controller_unit #(
    .DUTY_CYCLE_MS    (DUTY_MS),
    .UP_INITIAL_DUTY  (UP_INIT),
    .DOWN_INITIAL_DUTY(DOWN_INIT),
    .UP_DUTY_STEP     (UP_STEP),
    .DOWN_DUTY_STEP   (DOWN_STEP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of the settings and the tracking state
  cfg_t              cfg_now;
  logic [POS_W-1:0]  tgt_latch;
  dir_t              dir_q;
  logic [TIME_W-1:0] ramp_t0;
  logic [PWM_W-1:0]  pwm_q;
  logic              in1_q;
  logic              in2_q;

  in_t  tick_q[$];
  out_t drive_expect_q[$];

  int ticks_queued;
  int ticks_accepted;
  int results_checked;
  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int settings_used;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned pos_gap(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int clamp16(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // advances the tracking state by one tick and returns the drive it produces
  function automatic out_t step_actuator(in_t t);
    logic [POS_W-1:0]  tgt;
    logic [TIME_W-1:0] elapsed;
    int unsigned       err, window, init, step, phase, cyc;
    logic              pull, off;
    out_t              r;
    if (t.new_setpoint) begin
      tgt = t.target_position;
      if (tgt < cfg_now.min_position) tgt = cfg_now.min_position;
      if (tgt > cfg_now.max_position) tgt = cfg_now.max_position;
      tgt_latch = tgt;
      if (pos_gap(t.pot_position, tgt) < cfg_now.tolerance) begin
        pwm_q = PWM_OFF;
      end else if (!((tgt > t.pot_position && dir_q == DIR_PULL) ||
                     (tgt < t.pot_position && dir_q == DIR_LOOSEN))) begin
        dir_q   = (tgt > t.pot_position) ? DIR_PULL : DIR_LOOSEN;
        ramp_t0 = t.now_ms;
      end
    end
    if (!t.clutch_allow) pwm_q = PWM_OFF;
    if (dir_q != DIR_IDLE) begin
      err = pos_gap(t.pot_position, tgt_latch);
      if (err < cfg_now.tolerance) begin
        pwm_q = PWM_OFF;
      end else begin
        in1_q   = (t.pot_position < tgt_latch);
        in2_q   = ~in1_q;
        pull    = (dir_q == DIR_PULL);
        window  = pull ? 32'(cfg_now.ramp_up_ms) : 32'(cfg_now.ramp_down_ms);
        init    = pull ? UP_INIT : DOWN_INIT;
        step    = pull ? UP_STEP : DOWN_STEP;
        elapsed = t.now_ms - ramp_t0;
        off     = 1'b0;
        if (elapsed <= window) begin
          phase = elapsed % DUTY_MS;
          cyc   = elapsed / DUTY_MS;
          off   = (phase > init + cyc * step);
        end
        if (off) pwm_q = PWM_OFF;
        else if (err > cfg_now.slow_threshold) pwm_q = PWM_FULL;
        else pwm_q = pull ? cfg_now.slow_pwm_pull : cfg_now.slow_pwm_loosen;
      end
    end
    r.pwm_level      = pwm_q;
    r.bridge_in1     = in1_q;
    r.bridge_in2     = in2_q;
    r.solenoid_close = t.clutch_allow;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic queue_tick(input logic [POS_W-1:0] pos, input logic [TIME_W-1:0] now,
                            input logic sp, input logic [POS_W-1:0] tgt, input logic allow);
    in_t t;
    t.pot_position    = pos;
    t.now_ms          = now;
    t.new_setpoint    = sp;
    t.target_position = tgt;
    t.clutch_allow    = allow;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  // a control sequence: the actuator creeps toward its target while time advances
  task automatic queue_ramp_run(input int n);
    int                pos, tgt, step, jit;
    logic [TIME_W-1:0] now;
    logic              sp;
    pos = $urandom_range(0, 65535);
    tgt = $urandom_range(0, 65535);
    if ($urandom_range(99) < 15) now = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else now = $urandom;
    for (int k = 0; k < n; k++) begin
      sp = (k == 0) || ($urandom_range(99) < 8);
      if (sp && k != 0) begin
        jit = int'($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(3))
          0: tgt = $urandom_range(0, 65535);
          1: tgt = clamp16(pos + jit / 30);
          2: tgt = clamp16(tgt + jit);
          default: tgt = (tgt > pos) ? $urandom_range(0, pos) : $urandom_range(pos, 65535);
        endcase
      end
      queue_tick(pos[15:0], now, sp, sp ? tgt[15:0] : 16'($urandom), $urandom_range(99) >= 10);
      // mostly small steps, now and then a gap that leaves the ramp window
      if ($urandom_range(99) < 5) now = now + $urandom_range(300, 70000);
      else now = now + $urandom_range(0, 4);
      step = $urandom_range(0, 400);
      jit  = int'($urandom_range(0, 40)) - 20;
      if (pos < tgt) pos = (tgt - pos > step) ? pos + step : tgt + jit;
      else pos = (pos - tgt > step) ? pos - step : tgt + jit;
      pos = clamp16(pos);
    end
  endtask

  task automatic write_settings(input cfg_t c);
    cfg_idx_t idx;
    idx = REG_MIN_POSITION;
    for (int k = 0; k < 8; k++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_MIN_POSITION:    cfg_data <= c.min_position;
        REG_MAX_POSITION:    cfg_data <= c.max_position;
        REG_TOLERANCE:       cfg_data <= c.tolerance;
        REG_SLOW_THRESHOLD:  cfg_data <= c.slow_threshold;
        REG_RAMP_UP_MS:      cfg_data <= c.ramp_up_ms;
        REG_RAMP_DOWN_MS:    cfg_data <= c.ramp_down_ms;
        REG_SLOW_PWM_PULL:   cfg_data <= {8'h00, c.slow_pwm_pull};
        default:             cfg_data <= {8'h00, c.slow_pwm_loosen};
      endcase
      idx = idx.next();
    end
    @(posedge clk);
    cfg_we  <= 1'b0;
    cfg_now = c;
    settings_used++;
  endtask

  function automatic cfg_t pick_settings(input int kind);
    cfg_t c;
    case (kind)
      0: begin
        c.min_position    = 16'($urandom_range(0, 8000));
        c.max_position    = 16'($urandom_range(57000, 65535));
        c.tolerance       = 16'($urandom_range(0, 64));
        c.slow_threshold  = 16'($urandom_range(0, 3000));
        c.ramp_up_ms      = 16'($urandom_range(0, 400));
        c.ramp_down_ms    = 16'($urandom_range(0, 400));
        c.slow_pwm_pull   = 8'($urandom);
        c.slow_pwm_loosen = 8'($urandom);
      end
      1: c = {$urandom, $urandom, $urandom, 16'($urandom)};
      2: c = '0;
      default: c = '1;
    endcase
    return c;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  // waits until every tick is through, then lets the pipeline settle
  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || drive_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin : tick_driver
    in_t seen, nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) begin
        seen.pot_position    = in_chan.pot_position;
        seen.now_ms          = in_chan.now_ms;
        seen.new_setpoint    = in_chan.new_setpoint;
        seen.target_position = in_chan.target_position;
        seen.clutch_allow    = in_chan.clutch_allow;
        drive_expect_q.push_back(step_actuator(seen));
        ticks_accepted++;
      end
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = tick_q.pop_front();
        in_chan.valid           <= 1'b1;
        in_chan.pot_position    <= nxt.pot_position;
        in_chan.now_ms          <= nxt.now_ms;
        in_chan.new_setpoint    <= nxt.new_setpoint;
        in_chan.target_position <= nxt.target_position;
        in_chan.clutch_allow    <= nxt.clutch_allow;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_monitor
    out_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch("transaction with no tick pending", 1, 0);
        end else begin
          want = drive_expect_q.pop_front();
          results_checked++;
          if (out_chan.pwm_level !== want.pwm_level)
            report_mismatch("pwm_level", int'(out_chan.pwm_level), int'(want.pwm_level));
          if (out_chan.bridge_in1 !== want.bridge_in1)
            report_mismatch("bridge_in1", int'(out_chan.bridge_in1), int'(want.bridge_in1));
          if (out_chan.bridge_in2 !== want.bridge_in2)
            report_mismatch("bridge_in2", int'(out_chan.bridge_in2), int'(want.bridge_in2));
          if (out_chan.solenoid_close !== want.solenoid_close)
            report_mismatch("solenoid_close", int'(out_chan.solenoid_close),
                            int'(want.solenoid_close));
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #400000;
    $display("timeout waiting for drive results");
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    int   left, n;
    bit   paused;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    in_chan.valid           = 1'b0;
    in_chan.pot_position    = '0;
    in_chan.now_ms          = '0;
    in_chan.new_setpoint    = 1'b0;
    in_chan.target_position = '0;
    in_chan.clutch_allow    = 1'b0;
    out_chan.ready          = 1'b0;
    ticks_queued            = 0;
    ticks_accepted          = 0;
    results_checked         = 0;
    error_count             = 0;
    settings_used           = 0;
    set_idling(0);
    cfg_now.min_position    = 16'd0;
    cfg_now.max_position    = 16'd65535;
    cfg_now.tolerance       = 16'd16;
    cfg_now.slow_threshold  = 16'd256;
    cfg_now.ramp_up_ms      = 16'd200;
    cfg_now.ramp_down_ms    = 16'd200;
    cfg_now.slow_pwm_pull   = 8'd128;
    cfg_now.slow_pwm_loosen = 8'd128;
    tgt_latch               = '0;
    dir_q                   = DIR_IDLE;
    ramp_t0                 = '0;
    pwm_q                   = PWM_OFF;
    in1_q                   = 1'b0;
    in2_q                   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults first, without writes, then written back explicitly
    queue_tick(16'd0, 32'd0, 1'b0, 16'hFFFF, 1'b1);         // idle, target field ignored
    queue_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0); // idle with clutch open
    wait_drained();
    write_settings(cfg_now);
    queue_tick(16'd0, 32'd0, 1'b1, 16'hFFFF, 1'b1);         // pull ramp starts
    queue_tick(16'd10, 32'd6, 1'b0, 16'd0, 1'b1);           // off part of first duty cycle
    queue_tick(16'd20, 32'd21, 1'b0, 16'd0, 1'b1);
    queue_tick(16'd30, 32'd27, 1'b0, 16'd0, 1'b1);
    queue_tick(16'd40, 32'd28, 1'b0, 16'd0, 1'b0);          // clutch open while driving
    queue_tick(16'd500, 32'd201, 1'b0, 16'd0, 1'b1);        // past the ramp window
    queue_tick(16'd1000, 32'd210, 1'b1, 16'd40000, 1'b1);   // same direction, endpoint only
    queue_tick(16'd39800, 32'd220, 1'b0, 16'd0, 1'b1);      // slow zone
    queue_tick(16'd39990, 32'd230, 1'b0, 16'd0, 1'b1);      // within tolerance
    queue_tick(16'd39990, 32'd240, 1'b1, 16'd39995, 1'b1);  // new target within tolerance
    queue_tick(16'd39990, 32'd300, 1'b1, 16'd0, 1'b1);      // reversal to loosen
    queue_tick(16'd39000, 32'd305, 1'b0, 16'd0, 1'b1);
    queue_tick(16'd100, 32'd320, 1'b0, 16'd0, 1'b1);        // slow loosen
    queue_tick(16'd5000, 32'd400, 1'b1, 16'd3000, 1'b1);    // loosen kept
    queue_tick(16'd2000, 32'd410, 1'b0, 16'd0, 1'b1);       // overshoot flips bridge bits
    queue_tick(16'd0, 32'hFFFF_FFF8, 1'b1, 16'hFFFF, 1'b1); // ramp start just before wrap
    queue_tick(16'd100, 32'd3, 1'b0, 16'd0, 1'b1);
    queue_tick(16'd200, 32'd16, 1'b0, 16'd0, 1'b1);
    queue_tick(16'hFFFF, 32'd40, 1'b1, 16'd0, 1'b0);
    wait_drained();

    // min above max, zero tolerance, window extremes, slow pwm extremes
    c.min_position    = 16'd50000;
    c.max_position    = 16'd1000;
    c.tolerance       = 16'd0;
    c.slow_threshold  = 16'hFFFF;
    c.ramp_up_ms      = 16'd0;
    c.ramp_down_ms    = 16'hFFFF;
    c.slow_pwm_pull   = 8'd0;
    c.slow_pwm_loosen = 8'hFF;
    write_settings(c);
    queue_tick(16'd1000, 32'd100, 1'b1, 16'd1000, 1'b1);    // target equals position
    queue_tick(16'd1000, 32'd150, 1'b0, 16'd0, 1'b1);
    queue_tick(16'd200, 32'd160, 1'b1, 16'd60000, 1'b1);    // max clamp wins, pull
    queue_tick(16'd300, 32'd161, 1'b0, 16'd0, 1'b1);
    queue_tick(16'hFFFF, 32'd170, 1'b1, 16'd0, 1'b1);
    queue_tick(16'd1000, 32'd171, 1'b0, 16'd0, 1'b1);       // on target, never stops
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        3:       c = pick_settings(1);
        6:       c = pick_settings(2);
        7:       c = pick_settings(3);
        default: c = pick_settings(0);
      endcase
      write_settings(c);
      set_idling(p % 4);
      left   = 128;
      paused = 1'b0;
      while (left > 0) begin
        if (p == 1 && left <= 64 && !paused) begin
          // hold the sender back until every result is in
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 85) begin
          n = $urandom_range(15, 60);
          if (n > left) n = left;
          queue_ramp_run(n);
        end else begin
          n = $urandom_range(1, 5);
          if (n > left) n = left;
          for (int k = 0; k < n; k++)
            queue_tick(16'($urandom), $urandom, 1'($urandom_range(1)), 16'($urandom),
                       1'($urandom_range(1)));
        end
        left -= n;
      end
      wait_drained();
    end

    $display("%0d ticks driven under %0d register settings and four idling patterns",
             ticks_accepted, settings_used);
    $display("%0d drive transactions compared, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tarc_pkg.sv
hw/rtl/tarc_ifs.sv
hw/rtl/tarc_cfg.sv
hw/rtl/tarc_track.sv
hw/rtl/tarc_drive.sv
hw/rtl/throttle_actuator_ramp_controller_unit.sv
tb/tb_throttle_actuator_ramp_controller_unit.sv
